// ===== hw/rtl/jbh_pkg.sv =====
package jbh_pkg;

	localparam logic [7:0]  TILDE     = 8'h7E;
	localparam logic [7:0]  HIGH_LO   = 8'h80;
	localparam logic [7:0]  INIT_HI   = 8'h92;
	localparam logic [7:0]  MED_LO    = 8'h93;
	localparam logic [7:0]  MED_HI    = 8'h9C;
	localparam logic [7:0]  UPGRADE   = 8'h5C;
	localparam logic [7:0]  TERM_A    = 8'h60;
	localparam logic [7:0]  TERM_B    = 8'h5D;
	localparam logic [7:0]  FIN_ALT   = 8'h3C;
	localparam logic [15:0] SYL_BASE  = 16'hAC00;
	localparam logic [8:0]  N_MED     = 9'd21;
	localparam logic [15:0] N_FIN     = 16'd28;
	localparam logic [2:0]  WIN_DEPTH = 3'd6;

	typedef enum logic [3:0] {
		S_IDLE,
		S_STRIP,
		S_FEED_T,
		S_TAG_RD,
		S_FEED_TAG,
		S_FEED_IN,
		S_END,
		S_FLUSH,
		S_LAST
	} state_t;

	typedef enum logic [1:0] {
		SRC_TILDE,
		SRC_TAG,
		SRC_IN
	} src_t;

	typedef struct packed {
		logic latch;
		logic tag_open;
		logic tag_close;
		logic tag_push;
		logic rel_start;
		logic tag_rd;
		logic idx_inc;
		logic tag_clear;
		logic feed;
		src_t src;
		logic decode;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic in_tilde;
		logic in_high;
		logic fin;
		logic in_tag;
		logic cnt_zero;
		logic cnt_full;
		logic idx_last;
		logic win_full;
		logic win_empty;
		logic dec_emit;
		logic can_emit;
		logic out_free;
	} status_t;

	// medial index for bytes 0x93..0x9c
	function automatic logic [4:0] med_idx(input logic [7:0] b);
		unique case (b)
			8'h93:   med_idx = 5'd0;
			8'h94:   med_idx = 5'd2;
			8'h95:   med_idx = 5'd4;
			8'h96:   med_idx = 5'd6;
			8'h97:   med_idx = 5'd8;
			8'h98:   med_idx = 5'd12;
			8'h99:   med_idx = 5'd13;
			8'h9A:   med_idx = 5'd17;
			8'h9B:   med_idx = 5'd18;
			8'h9C:   med_idx = 5'd20;
			default: med_idx = 5'd0;
		endcase
	endfunction

	// final-consonant index, zero when the byte is no final
	function automatic logic [4:0] fin_idx(input logic [7:0] b);
		unique case (b)
			FIN_ALT: fin_idx = 5'd25;
			8'h9D:   fin_idx = 5'd1;
			8'h9E:   fin_idx = 5'd2;
			8'h9F:   fin_idx = 5'd4;
			8'hA0:   fin_idx = 5'd0;
			8'hA1:   fin_idx = 5'd5;
			8'hA2:   fin_idx = 5'd7;
			8'hA3:   fin_idx = 5'd8;
			8'hA4:   fin_idx = 5'd9;
			8'hA5:   fin_idx = 5'd13;
			8'hA6:   fin_idx = 5'd10;
			8'hA7:   fin_idx = 5'd15;
			8'hA8:   fin_idx = 5'd16;
			8'hA9:   fin_idx = 5'd17;
			8'hAA:   fin_idx = 5'd18;
			8'hAB:   fin_idx = 5'd19;
			8'hAC:   fin_idx = 5'd20;
			8'hAD:   fin_idx = 5'd21;
			8'hAE:   fin_idx = 5'd22;
			8'hAF:   fin_idx = 5'd23;
			default: fin_idx = 5'd0;
		endcase
	endfunction

endpackage

// ===== hw/rtl/jbh_in_if.sv =====
interface jbh_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       string_end;

	modport source (output valid, output text_byte, output string_end, input ready);
	modport sink   (input valid, input text_byte, input string_end, output ready);
endinterface

// ===== hw/rtl/jbh_out_if.sv =====
interface jbh_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] code_point;
	logic        char_valid;
	logic        last_of_string;

	modport source (output valid, output code_point, output char_valid,
		output last_of_string, input ready);
	modport sink   (input valid, input code_point, input char_valid,
		input last_of_string, output ready);
endinterface

// ===== hw/rtl/jbh_ctrl.sv =====
module jbh_ctrl
	import jbh_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t st,
	output cmd_t    cmd
);

	state_t state_q, state_d;
	logic   rel_q, rel_d;
	logic   then_q, then_d;
	logic   dec_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rel_q   <= 1'b0;
			then_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			rel_q   <= rel_d;
			then_q  <= then_d;
		end
	end

	// a decode may run unless it emits and the result path is blocked
	assign dec_ok = !st.dec_emit || st.can_emit;

	always_comb begin
		state_d  = state_q;
		rel_d    = rel_q;
		then_d   = then_q;
		cmd      = '0;
		cmd.src  = SRC_IN;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_STRIP;
				end
			end
			S_STRIP: begin
				rel_d  = 1'b0;
				then_d = 1'b0;
				if (!st.in_tag) begin
					if (st.in_tilde) begin
						cmd.tag_open = 1'b1;
						state_d      = S_END;
					end else begin
						state_d = S_FEED_IN;
					end
				end else if (st.in_tilde) begin
					if (!st.cnt_zero) begin
						cmd.tag_close = 1'b1;
						state_d       = S_END;
					end else begin
						state_d = S_FEED_T;
					end
				end else if (st.in_high || st.cnt_full) begin
					cmd.rel_start = 1'b1;
					rel_d         = 1'b1;
					then_d        = 1'b1;
					state_d       = S_FEED_T;
				end else begin
					cmd.tag_push = 1'b1;
					state_d      = S_END;
				end
			end
			S_FEED_T: begin
				cmd.src = SRC_TILDE;
				if (st.win_full) begin
					cmd.decode = dec_ok;
				end else begin
					cmd.feed = 1'b1;
					if (!rel_q)
						state_d = S_END;
					else if (!st.cnt_zero)
						state_d = S_TAG_RD;
					else
						state_d = then_q ? S_FEED_IN : S_END;
				end
			end
			S_TAG_RD: begin
				cmd.tag_rd = 1'b1;
				state_d    = S_FEED_TAG;
			end
			S_FEED_TAG: begin
				cmd.src = SRC_TAG;
				if (st.win_full) begin
					cmd.decode = dec_ok;
				end else begin
					cmd.feed = 1'b1;
					if (st.idx_last) begin
						cmd.tag_clear = 1'b1;
						state_d       = then_q ? S_FEED_IN : S_END;
					end else begin
						cmd.idx_inc = 1'b1;
						state_d     = S_TAG_RD;
					end
				end
			end
			S_FEED_IN: begin
				cmd.src = SRC_IN;
				if (st.win_full) begin
					cmd.decode = dec_ok;
				end else begin
					cmd.feed = 1'b1;
					state_d  = S_END;
				end
			end
			S_END: begin
				if (!st.fin) begin
					state_d = S_IDLE;
				end else if (st.in_tag) begin
					cmd.rel_start = 1'b1;
					rel_d         = 1'b1;
					then_d        = 1'b0;
					state_d       = S_FEED_T;
				end else begin
					state_d = S_FLUSH;
				end
			end
			S_FLUSH: begin
				if (st.win_empty)
					state_d = S_LAST;
				else
					cmd.decode = dec_ok;
			end
			S_LAST: begin
				if (st.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ===== hw/rtl/jbh_datapath.sv =====
module jbh_datapath
	import jbh_pkg::*;
#(
	parameter int MAX_TAG_LEN = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        text_byte,
	input  logic              string_end,
	input  cmd_t              cmd,
	output status_t           st,
	jbh_out_if.source         char_out
);

	localparam int CW = $clog2(MAX_TAG_LEN + 1);
	localparam int IW = (MAX_TAG_LEN > 1) ? $clog2(MAX_TAG_LEN) : 1;

	// input byte and tag store
	logic [7:0]    byte_q;
	logic          fin_q;
	logic          in_tag_q;
	logic [CW-1:0] tag_cnt_q;
	logic [CW-1:0] idx_q;
	logic [7:0]    tag_mem [MAX_TAG_LEN];
	logic [7:0]    rd_q;

	// decode window
	logic [7:0] win_q [6];
	logic [2:0] wcnt_q;

	// held result and output register
	logic        pend_v_q;
	logic [15:0] pend_cp_q;
	logic        pend_cv_q;
	logic        out_v_q;
	logic [15:0] out_cp_q;
	logic        out_cv_q;
	logic        out_last_q;

	logic [7:0]  feed_byte;
	logic        dec_emit;
	logic [2:0]  dec_len;
	logic [15:0] dec_cp;
	logic [7:0]  shifted [6];
	logic        out_free;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			byte_q <= text_byte;
			fin_q  <= string_end;
		end
		if (cmd.tag_push)
			tag_mem[tag_cnt_q[IW-1:0]] <= byte_q;
		if (cmd.tag_rd)
			rd_q <= tag_mem[idx_q[IW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_tag_q  <= 1'b0;
			tag_cnt_q <= '0;
			idx_q     <= '0;
		end else begin
			if (cmd.tag_open) begin
				in_tag_q  <= 1'b1;
				tag_cnt_q <= '0;
			end
			if (cmd.tag_close) begin
				in_tag_q  <= 1'b0;
				tag_cnt_q <= '0;
			end
			if (cmd.tag_push)
				tag_cnt_q <= tag_cnt_q + 1'b1;
			if (cmd.rel_start) begin
				in_tag_q <= 1'b0;
				idx_q    <= '0;
			end
			if (cmd.idx_inc)
				idx_q <= idx_q + 1'b1;
			if (cmd.tag_clear)
				tag_cnt_q <= '0;
		end
	end

	always_comb begin
		case (cmd.src)
			SRC_TILDE: feed_byte = TILDE;
			SRC_TAG:   feed_byte = rd_q;
			default:   feed_byte = byte_q;
		endcase
	end

	// decode of the window front
	always_comb begin
		logic [4:0] ii;
		logic [4:0] mi;
		logic [4:0] fi;
		logic [4:0] fcand;
		logic [2:0] c;
		logic       cm_ok;
		logic [4:0] cm;
		logic [7:0] b1;
		logic [7:0] b2;
		logic [7:0] bf;
		logic [8:0] sy;
		b1       = win_q[1];
		b2       = win_q[2];
		ii       = 5'(win_q[0] - HIGH_LO);
		mi       = med_idx(b1);
		fi       = 5'd0;
		c        = 3'd2;
		cm_ok    = 1'b0;
		cm       = 5'd0;
		bf       = 8'h00;
		fcand    = 5'd0;
		dec_emit = 1'b0;
		dec_len  = 3'd1;
		dec_cp   = {8'h00, win_q[0]};
		if (win_q[0] < HIGH_LO) begin
			dec_emit = 1'b1;
		end else if (win_q[0] <= INIT_HI && wcnt_q > 3'd1
				&& b1 >= MED_LO && b1 <= MED_HI) begin
			if (wcnt_q > 3'd2) begin
				// compound vowels
				if (b2 == UPGRADE || b2 == MED_HI) begin
					case (b1)
						8'h93: begin cm_ok = 1'b1; cm = 5'd1;  end
						8'h95: begin cm_ok = 1'b1; cm = 5'd5;  end
						8'h9B: begin cm_ok = 1'b1; cm = 5'd19; end
						8'h97: begin cm_ok = 1'b1; cm = 5'd11; end
						8'h99: begin cm_ok = 1'b1; cm = 5'd16; end
						8'h96: begin cm_ok = (b2 == UPGRADE); cm = 5'd7; end
						default: cm_ok = 1'b0;
					endcase
				end else if (b1 == 8'h97 && b2 == 8'h93) begin
					cm_ok = 1'b1;
					cm    = 5'd9;
				end else if (b1 == 8'h99 && b2 == 8'h95) begin
					cm_ok = 1'b1;
					cm    = 5'd14;
				end
				if (cm_ok) begin
					mi = cm;
					c  = 3'd3;
					if (wcnt_q > 3'd3 && win_q[3] == UPGRADE
							&& (cm == 5'd9 || cm == 5'd14)) begin
						mi = cm + 5'd1;
						c  = 3'd4;
					end
				end
			end
			if (c < wcnt_q) begin
				bf    = win_q[c];
				fcand = fin_idx(bf);
				if (bf == TERM_A || bf == TERM_B) begin
					c = c + 3'd1;
				end else if (fcand != 5'd0) begin
					fi = fcand;
					c  = c + 3'd1;
					if (c < wcnt_q && (win_q[c] == TERM_A || win_q[c] == TERM_B))
						c = c + 3'd1;
				end
			end
			sy       = 9'(ii) * N_MED + 9'(mi);
			dec_emit = 1'b1;
			dec_len  = c;
			dec_cp   = SYL_BASE + 16'(sy) * N_FIN + 16'(fi);
		end
	end

	always_comb begin
		for (int i = 0; i < 6; i++) begin
			if (i + int'(dec_len) < 6)
				shifted[i] = win_q[3'(i + int'(dec_len))];
			else
				shifted[i] = win_q[i];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.feed)
			win_q[wcnt_q] <= feed_byte;
		else if (cmd.decode)
			win_q <= shifted;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wcnt_q <= '0;
		end else if (cmd.feed) begin
			wcnt_q <= wcnt_q + 3'd1;
		end else if (cmd.decode) begin
			wcnt_q <= wcnt_q - dec_len;
		end
	end

	// results: the newest one waits until it is known not to be last
	assign out_free = !out_v_q || char_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (out_v_q && char_out.ready)
				out_v_q <= 1'b0;
			if (cmd.decode && dec_emit) begin
				pend_v_q <= 1'b1;
				if (pend_v_q)
					out_v_q <= 1'b1;
			end
			if (cmd.finish) begin
				pend_v_q <= 1'b0;
				out_v_q  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.decode && dec_emit) begin
			pend_cp_q <= dec_cp;
			pend_cv_q <= 1'b1;
			if (pend_v_q) begin
				out_cp_q   <= pend_cp_q;
				out_cv_q   <= pend_cv_q;
				out_last_q <= 1'b0;
			end
		end
		if (cmd.finish) begin
			out_cp_q   <= pend_v_q ? pend_cp_q : 16'h0000;
			out_cv_q   <= pend_v_q ? pend_cv_q : 1'b0;
			out_last_q <= 1'b1;
		end
	end

	assign char_out.valid          = out_v_q;
	assign char_out.code_point     = out_cp_q;
	assign char_out.char_valid     = out_cv_q;
	assign char_out.last_of_string = out_last_q;

	assign st.in_tilde  = (byte_q == TILDE);
	assign st.in_high   = (byte_q >= HIGH_LO);
	assign st.fin       = fin_q;
	assign st.in_tag    = in_tag_q;
	assign st.cnt_zero  = (tag_cnt_q == '0);
	assign st.cnt_full  = (tag_cnt_q == CW'(MAX_TAG_LEN));
	assign st.idx_last  = ((idx_q + 1'b1) == tag_cnt_q);
	assign st.win_full  = (wcnt_q == WIN_DEPTH);
	assign st.win_empty = (wcnt_q == 3'd0);
	assign st.dec_emit  = dec_emit;
	assign st.can_emit  = !pend_v_q || out_free;
	assign st.out_free  = out_free;

endmodule

// ===== hw/rtl/jamo_byte_to_hangul_decoder.sv =====
// a plain byte passes S_IDLE, S_STRIP, S_FEED_IN and S_END before the next transfer
// a byte held inside a tag passes S_STRIP and S_END, a failed tag replays via S_TAG_RD, S_FEED_TAG
// a full window stalls the feed for decodes; at string end S_FLUSH drains it, then S_LAST emits
// a result leaves one decode later than it is formed, since it waits to learn if it is last
// reset: arst_n clears the state machine, tag and window counts and all valid flags
module jamo_byte_to_hangul_decoder
	import jbh_pkg::*;
#(
	parameter int MAX_TAG_LEN = 24
) (
	input  logic      clk,
	input  logic      arst_n,
	jbh_in_if.sink    byte_in,
	jbh_out_if.source char_out
);

	// command and status between sequencer and datapath
	cmd_t    cmd;
	status_t st;

	// sequencer: tag stripping decisions, replay, window drain
	jbh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (byte_in.valid),
		.in_ready (byte_in.ready),
		.st       (st),
		.cmd      (cmd)
	);

	// datapath: tag store, six-byte decode window, result registers
	jbh_datapath #(
		.MAX_TAG_LEN (MAX_TAG_LEN)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_byte  (byte_in.text_byte),
		.string_end (byte_in.string_end),
		.cmd        (cmd),
		.st         (st),
		.char_out   (char_out)
	);

endmodule
